// ===== sv/rar_pkg.sv =====
`timescale 1ns / 1ps

package rar_pkg;

	// defaults for the top level parameters
	localparam int RX_COUNT_LIMIT_DEF = 2048;
	localparam int PERIOD_LOG2_DEF    = 6;

	// trigger queue between front and back
	localparam int QUEUE_DEPTH = 4;

	// advertisement layout
	localparam int ADV_WORDS = 55;
	localparam int IDX_W     = 6;

	// trigger kinds
	localparam logic KIND_SOLICIT  = 1'b0;
	localparam logic KIND_PERIODIC = 1'b1;

	// input word codes
	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	// configuration register indexes
	localparam int          CFG_IDX_W  = 2;
	localparam logic [1:0] CFG_MAC    = 2'd0;
	localparam logic [1:0] CFG_PREFIX = 2'd1;

	localparam logic [47:0] MAC_RESET    = 48'h0600_0000_0000;
	localparam logic [63:0] PREFIX_RESET = 64'h0;

	// checksum contribution of all fixed words of pseudo-header and ICMPv6 body
	localparam int          CSUM_W    = 21;
	localparam logic [CSUM_W-1:0] CSUM_BASE = CSUM_W'(
		32'hfe80 + 32'hff02 + 32'h0001 + 32'h0038 + 32'h003a +
		32'h8600 + 32'h4000 + 32'h012c + 32'h0078 + 32'h0304 +
		32'h40c0 + 32'h012c + 32'h00b4 + 32'h0101);
	// variable checksum words: interface id (4), prefix (4), MAC (3)
	localparam int CSUM_VAR_WORDS = 11;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [15:0] tx_word;
		logic        tx_last;
		logic        trigger_kind;
	} out_t;

	typedef struct packed {
		logic empty;
		logic full;
	} q_status_t;

	typedef enum logic {
		ST_IDLE,
		ST_EMIT
	} back_state_t;

endpackage

// ===== sv/rar_queue.sv =====
`timescale 1ns / 1ps

module rar_queue #(
	parameter int DEPTH = rar_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                push_kind,
	input  logic                pop,
	output logic                head_kind,
	output rar_pkg::q_status_t  status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [DEPTH-1:0] kind_q;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign status.empty = (count_q == '0);
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign head_kind    = kind_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			kind_q[wr_ptr_q] <= push_kind;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && status.full && !pop))
		else $error("trigger queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && status.empty))
		else $error("trigger queue underflow");

endmodule

// ===== sv/rar_front.sv =====
`timescale 1ns / 1ps

module rar_front #(
	parameter int RX_COUNT_LIMIT = rar_pkg::RX_COUNT_LIMIT_DEF,
	parameter int PERIOD_LOG2    = rar_pkg::PERIOD_LOG2_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         accept,
	input  rar_pkg::in_t item,
	output logic         push,
	output logic         push_kind
);

	localparam int CNT_W = $clog2(RX_COUNT_LIMIT + 1);

	// byte positions inside the received frame
	localparam logic [CNT_W-1:0] POS_ETYPE_HI = CNT_W'(12);
	localparam logic [CNT_W-1:0] POS_ETYPE_LO = CNT_W'(13);
	localparam logic [CNT_W-1:0] POS_DST_FIRST = CNT_W'(38);
	localparam logic [CNT_W-1:0] POS_DST_SECOND = CNT_W'(39);
	localparam logic [CNT_W-1:0] POS_DST_LAST = CNT_W'(53);
	localparam logic [CNT_W-1:0] POS_ICMP_TYPE = CNT_W'(54);
	localparam logic [CNT_W-1:0] MIN_LEN = CNT_W'(54);
	localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(RX_COUNT_LIMIT);

	logic [CNT_W-1:0]       byte_count_q;
	logic                   etype_q;
	logic                   dest_q;
	logic                   solicit_q;
	logic [PERIOD_LOG2-1:0] window_q;
	logic                   first_tick_q;

	logic [CNT_W-1:0]       count_nxt;
	logic                   etype_nxt;
	logic                   dest_nxt;
	logic                   solicit_nxt;
	logic [PERIOD_LOG2-1:0] window_nxt;
	logic [7:0]             dest_exp;
	logic                   is_byte;
	logic                   is_tick;
	logic                   hit;
	logic                   fire;

	assign is_byte = accept && (item.cmd == rar_pkg::CMD_BYTE);
	assign is_tick = accept && (item.cmd == rar_pkg::CMD_TICK);

	// expected byte of ff02::2
	always_comb begin
		priority if (byte_count_q == POS_DST_FIRST)
			dest_exp = 8'hff;
		else if (byte_count_q == POS_DST_SECOND || byte_count_q == POS_DST_LAST)
			dest_exp = 8'h02;
		else
			dest_exp = 8'h00;
	end

	// frame classification, one byte per word
	always_comb begin
		count_nxt   = byte_count_q;
		etype_nxt   = etype_q;
		dest_nxt    = dest_q;
		solicit_nxt = solicit_q;
		if (byte_count_q < CNT_LIMIT) begin
			priority if (byte_count_q == POS_ETYPE_HI)
				etype_nxt = (item.rx_byte == 8'h86);
			else if (byte_count_q == POS_ETYPE_LO)
				etype_nxt = etype_q && (item.rx_byte == 8'hdd);
			else if (byte_count_q == POS_DST_FIRST)
				dest_nxt = (item.rx_byte == dest_exp);
			else if (byte_count_q > POS_DST_FIRST && byte_count_q < POS_ICMP_TYPE)
				dest_nxt = dest_q && (item.rx_byte == dest_exp);
			else if (byte_count_q == POS_ICMP_TYPE)
				solicit_nxt = (item.rx_byte == 8'h85);
			count_nxt = byte_count_q + 1'b1;
		end
	end

	assign hit = (count_nxt > MIN_LEN) && etype_nxt && dest_nxt && solicit_nxt;

	// periodic window
	assign window_nxt = window_q + 1'b1;
	assign fire       = first_tick_q || (window_nxt == '0);

	assign push      = (is_tick && fire) || (is_byte && item.frame_end && hit);
	assign push_kind = is_tick ? rar_pkg::KIND_PERIODIC : rar_pkg::KIND_SOLICIT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q <= '0;
			etype_q      <= 1'b0;
			dest_q       <= 1'b0;
			solicit_q    <= 1'b0;
			window_q     <= '0;
			first_tick_q <= 1'b1;
		end else begin
			if (is_tick) begin
				window_q     <= window_nxt;
				first_tick_q <= 1'b0;
			end
			if (is_byte) begin
				if (item.frame_end) begin
					byte_count_q <= '0;
					etype_q      <= 1'b0;
					dest_q       <= 1'b0;
					solicit_q    <= 1'b0;
				end else begin
					byte_count_q <= count_nxt;
					etype_q      <= etype_nxt;
					dest_q       <= dest_nxt;
					solicit_q    <= solicit_nxt;
				end
			end
		end
	end

endmodule

// ===== sv/rar_back.sv =====
`timescale 1ns / 1ps

module rar_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [47:0]        mac_addr,
	input  logic [63:0]        prefix_hi,
	input  rar_pkg::q_status_t q_status,
	input  logic               head_kind,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output rar_pkg::out_t      out_data
);

	localparam logic [rar_pkg::IDX_W-1:0] LAST_IDX  = rar_pkg::IDX_W'(rar_pkg::ADV_WORDS - 1);
	localparam logic [rar_pkg::IDX_W-1:0] FOLD_IDX  = rar_pkg::IDX_W'(rar_pkg::CSUM_VAR_WORDS);
	localparam logic [rar_pkg::IDX_W-1:0] CSUM_IDX  = rar_pkg::IDX_W'(28);

	rar_pkg::back_state_t state_q, state_nxt;

	logic [rar_pkg::IDX_W-1:0]  idx_q;
	logic                       kind_q;
	logic [rar_pkg::CSUM_W-1:0] acc_q;
	logic [15:0]                csum_q;
	logic                       out_valid_q;
	rar_pkg::out_t              out_q;

	logic        load;
	logic [15:0] word;
	logic [15:0] var_word;
	logic [16:0] fold1;
	logic [16:0] fold2;
	logic [7:0]  eui0;

	assign eui0 = mac_addr[47:40] ^ 8'h02;

	// control
	always_comb begin
		state_nxt = state_q;
		pop       = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			rar_pkg::ST_IDLE: begin
				if (!q_status.empty) begin
					pop       = 1'b1;
					state_nxt = rar_pkg::ST_EMIT;
				end
			end
			rar_pkg::ST_EMIT: begin
				load = !out_valid_q || out_ready;
				if (load && idx_q == LAST_IDX)
					state_nxt = rar_pkg::ST_IDLE;
			end
			default: state_nxt = rar_pkg::ST_IDLE;
		endcase
	end

	// frame word at the current index
	always_comb begin
		unique case (idx_q)
			6'd0:    word = 16'h3333;
			6'd2:    word = 16'h0001;
			6'd3:    word = mac_addr[47:32];
			6'd4:    word = mac_addr[31:16];
			6'd5:    word = mac_addr[15:0];
			6'd6:    word = 16'h86dd;
			6'd7:    word = 16'h6000;
			6'd9:    word = 16'h0038;
			6'd10:   word = 16'h3aff;
			6'd11:   word = 16'hfe80;
			6'd15:   word = {eui0, mac_addr[39:32]};
			6'd16:   word = {mac_addr[31:24], 8'hff};
			6'd17:   word = {8'hfe, mac_addr[23:16]};
			6'd18:   word = mac_addr[15:0];
			6'd19:   word = 16'hff02;
			6'd26:   word = 16'h0001;
			6'd27:   word = 16'h8600;
			6'd28:   word = csum_q;
			6'd29:   word = 16'h4000;
			6'd30:   word = 16'h012c;
			6'd34:   word = 16'h0078;
			6'd35:   word = 16'h0304;
			6'd36:   word = 16'h40c0;
			6'd38:   word = 16'h012c;
			6'd40:   word = 16'h00b4;
			6'd43:   word = prefix_hi[63:48];
			6'd44:   word = prefix_hi[47:32];
			6'd45:   word = prefix_hi[31:16];
			6'd46:   word = prefix_hi[15:0];
			6'd51:   word = 16'h0101;
			6'd52:   word = mac_addr[47:32];
			6'd53:   word = mac_addr[31:16];
			6'd54:   word = mac_addr[15:0];
			default: word = 16'h0000;
		endcase
	end

	// variable checksum words, one per emitted word while idx < 11
	always_comb begin
		unique case (idx_q[3:0])
			4'd0:    var_word = {eui0, mac_addr[39:32]};
			4'd1:    var_word = {mac_addr[31:24], 8'hff};
			4'd2:    var_word = {8'hfe, mac_addr[23:16]};
			4'd3:    var_word = mac_addr[15:0];
			4'd4:    var_word = prefix_hi[63:48];
			4'd5:    var_word = prefix_hi[47:32];
			4'd6:    var_word = prefix_hi[31:16];
			4'd7:    var_word = prefix_hi[15:0];
			4'd8:    var_word = mac_addr[47:32];
			4'd9:    var_word = mac_addr[31:16];
			4'd10:   var_word = mac_addr[15:0];
			default: var_word = 16'h0000;
		endcase
	end

	// end-around carry fold, two passes are enough for the accumulator width
	assign fold1 = {1'b0, acc_q[15:0]} + 17'(acc_q[rar_pkg::CSUM_W-1:16]);
	assign fold2 = {1'b0, fold1[15:0]} + 17'(fold1[16]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rar_pkg::ST_IDLE;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (load) begin
				out_valid_q <= 1'b1;
				idx_q       <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (pop)
			kind_q <= head_kind;
		if (load) begin
			out_q.tx_word      <= word;
			out_q.tx_last      <= (idx_q == LAST_IDX);
			out_q.trigger_kind <= kind_q;
			if (idx_q == '0)
				acc_q <= rar_pkg::CSUM_BASE + rar_pkg::CSUM_W'(var_word);
			else if (idx_q < FOLD_IDX)
				acc_q <= acc_q + rar_pkg::CSUM_W'(var_word);
			if (idx_q == FOLD_IDX)
				csum_q <= ~fold2[15:0];
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == rar_pkg::ST_IDLE |-> idx_q == '0)
		else $error("word index not at zero while idle");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= LAST_IDX)
		else $error("word index beyond frame");

	a_csum_before_use: assert property (@(posedge clk) disable iff (!arst_n)
		load && idx_q == CSUM_IDX |-> $past(idx_q) >= FOLD_IDX)
		else $error("checksum word emitted before fold");

endmodule

// ===== sv/ipv6_router_advert_responder_unit.sv =====
`timescale 1ns / 1ps
// An accepted triggering byte or tick passes the queue, back-end state and output register
// before the first word is valid; the 55 words follow one per cycle while out_ready is high.
// Throughput: one input word per cycle while the 4-entry trigger queue has room; the back end
// sends one burst of 55 words per trigger and goes back to its idle state between bursts.
// Reset (arst_n low) clears frame tracking, tick window, queue and output; no clearing pass.

module ipv6_router_advert_responder_unit #(
	parameter int RX_COUNT_LIMIT = rar_pkg::RX_COUNT_LIMIT_DEF,
	parameter int PERIOD_LOG2    = rar_pkg::PERIOD_LOG2_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  rar_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output rar_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [rar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data
);

	logic [47:0]        mac_q;
	logic [63:0]        prefix_q;
	rar_pkg::q_status_t q_status;
	logic               push;
	logic               push_kind;
	logic               pop;
	logic               head_kind;
	logic               in_accept;

	assign in_ready  = !q_status.full;
	assign in_accept = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_q    <= rar_pkg::MAC_RESET;
			prefix_q <= rar_pkg::PREFIX_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == rar_pkg::CFG_MAC)
				mac_q <= cfg_data[47:0];
			else if (cfg_index == rar_pkg::CFG_PREFIX)
				prefix_q <= cfg_data;
		end
	end

	rar_front #(
		.RX_COUNT_LIMIT (RX_COUNT_LIMIT),
		.PERIOD_LOG2    (PERIOD_LOG2)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.item      (in_data),
		.push      (push),
		.push_kind (push_kind)
	);

	rar_queue #(
		.DEPTH (rar_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_kind (push_kind),
		.pop       (pop),
		.head_kind (head_kind),
		.status    (q_status)
	);

	rar_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mac_addr  (mac_q),
		.prefix_hi (prefix_q),
		.q_status  (q_status),
		.head_kind (head_kind),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== tb/sv/ipv6_router_advert_responder_unit_chk.sv =====
`timescale 1ns / 1ps

module ipv6_router_advert_responder_unit_chk #(
	parameter int RX_COUNT_LIMIT = rar_pkg::RX_COUNT_LIMIT_DEF,
	parameter int PERIOD_LOG2    = rar_pkg::PERIOD_LOG2_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  rar_pkg::in_t                  in_data,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  rar_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rar_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [63:0]                   cfg_data,
	output int                            fail_count,
	output int                            words_due,
	output int                            solicit_bursts,
	output int                            periodic_bursts,
	output int                            words_checked
);

	localparam int ADV_BYTES = 2 * rar_pkg::ADV_WORDS;

	// byte offsets inside a received frame
	localparam int POS_ETYPE = 12;
	localparam int POS_DST   = 38;
	localparam int POS_ICMP  = 54;

	localparam logic [7:0] ETYPE_HI   = 8'h86;
	localparam logic [7:0] ETYPE_LO   = 8'hdd;
	localparam logic [7:0] ICMP_RS    = 8'h85;
	localparam logic [7:0] NH_ICMP6   = 8'h3a;
	localparam logic [7:0] ICMP_PLEN  = 8'h38;

	// RA header, flags, lifetimes and the prefix option header
	localparam logic [255:0] RA_BODY = {
		64'h86000000_4000012c, 64'h00000000_00000078,
		64'h030440c0_0000012c, 64'h000000b4_00000000};

	logic [47:0]   own_mac;
	logic [63:0]   adv_prefix;
	int            rx_count;
	logic          eth_ok;
	logic          dst_ok;
	logic          rs_ok;
	int            tick_win;
	logic          first_tick;
	rar_pkg::out_t adv_due[$];
	rar_pkg::out_t adv_head;

	// ff02::2, byte by byte
	function automatic logic [7:0] all_routers_byte(input int i);
		if (i == 0)
			return 8'hff;
		if (i == 1 || i == 15)
			return 8'h02;
		return 8'h00;
	endfunction

	// whole advertisement frame, byte 0 in the top bits
	function automatic logic [8*ADV_BYTES-1:0] advert_frame(input logic [47:0] mac,
			input logic [63:0] pfx);
		logic [7:0]             f [0:ADV_BYTES-1];
		logic [31:0]            sum;
		logic [8*ADV_BYTES-1:0] flat;
		int                     i;
		for (i = 0; i < ADV_BYTES; i++)
			f[i] = 8'h00;
		// ethernet: 33:33:00:00:00:01 <- own mac, IPv6
		f[0] = 8'h33;
		f[1] = 8'h33;
		f[5] = 8'h01;
		for (i = 0; i < 6; i++)
			f[6 + i] = mac[47 - 8*i -: 8];
		f[12] = ETYPE_HI;
		f[13] = ETYPE_LO;
		// IPv6 header
		f[14] = 8'h60;
		f[19] = ICMP_PLEN;
		f[20] = NH_ICMP6;
		f[21] = 8'hff;
		// fe80:: with EUI-64 id, U/L bit flipped
		f[22] = 8'hfe;
		f[23] = 8'h80;
		f[30] = mac[47:40] ^ 8'h02;
		f[31] = mac[39:32];
		f[32] = mac[31:24];
		f[33] = 8'hff;
		f[34] = 8'hfe;
		f[35] = mac[23:16];
		f[36] = mac[15:8];
		f[37] = mac[7:0];
		// to ff02::1
		f[38] = 8'hff;
		f[39] = 8'h02;
		f[53] = 8'h01;
		for (i = 0; i < 32; i++)
			f[POS_ICMP + i] = RA_BODY[255 - 8*i -: 8];
		for (i = 0; i < 8; i++)
			f[86 + i] = pfx[63 - 8*i -: 8];
		// source link-layer option
		f[102] = 8'h01;
		f[103] = 8'h01;
		for (i = 0; i < 6; i++)
			f[104 + i] = mac[47 - 8*i -: 8];

		// one's-complement sum over pseudo-header and ICMPv6 message
		sum = 32'(ICMP_PLEN) + 32'(NH_ICMP6);
		for (i = 22; i < POS_ICMP; i += 2)
			sum += 32'({f[i], f[i + 1]});
		for (i = POS_ICMP; i < ADV_BYTES; i += 2)
			sum += 32'({f[i], f[i + 1]});
		while (sum[31:16] != 16'h0)
			sum = 32'(sum[15:0]) + 32'(sum[31:16]);
		sum = ~sum;
		f[POS_ICMP + 2] = sum[15:8];
		f[POS_ICMP + 3] = sum[7:0];

		for (i = 0; i < ADV_BYTES; i++)
			flat[8*(ADV_BYTES - 1 - i) +: 8] = f[i];
		return flat;
	endfunction

	// queue the 55 words of one burst
	task automatic queue_advert(input logic kind);
		logic [8*ADV_BYTES-1:0] flat;
		rar_pkg::out_t          w;
		int                     k;
		flat = advert_frame(own_mac, adv_prefix);
		for (k = 0; k < rar_pkg::ADV_WORDS; k++) begin
			w.tx_word      = flat[8*ADV_BYTES - 1 - 16*k -: 16];
			w.tx_last      = (k == rar_pkg::ADV_WORDS - 1);
			w.trigger_kind = kind;
			adv_due.push_back(w);
		end
		if (kind == rar_pkg::KIND_SOLICIT)
			solicit_bursts++;
		else
			periodic_bursts++;
	endtask

	// frame tracking and tick window for one accepted input word
	task automatic take_input(input rar_pkg::in_t w);
		int   mask;
		logic hit;
		if (w.cmd == rar_pkg::CMD_TICK) begin
			mask     = (1 << PERIOD_LOG2) - 1;
			tick_win = (tick_win + 1) & mask;
			if (first_tick || tick_win == 0)
				queue_advert(rar_pkg::KIND_PERIODIC);
			first_tick = 1'b0;
		end else begin
			// bytes past the limit are dropped, their end mark still counts
			if (rx_count < RX_COUNT_LIMIT) begin
				if (rx_count == POS_ETYPE)
					eth_ok = (w.rx_byte == ETYPE_HI);
				else if (rx_count == POS_ETYPE + 1)
					eth_ok = eth_ok && (w.rx_byte == ETYPE_LO);
				else if (rx_count == POS_DST)
					dst_ok = (w.rx_byte == all_routers_byte(0));
				else if (rx_count > POS_DST && rx_count < POS_ICMP)
					dst_ok = dst_ok && (w.rx_byte == all_routers_byte(rx_count - POS_DST));
				else if (rx_count == POS_ICMP)
					rs_ok = (w.rx_byte == ICMP_RS);
				rx_count++;
			end
			if (w.frame_end) begin
				hit      = rx_count > POS_ICMP && eth_ok && dst_ok && rs_ok;
				rx_count = 0;
				eth_ok   = 1'b0;
				dst_ok   = 1'b0;
				rs_ok    = 1'b0;
				if (hit)
					queue_advert(rar_pkg::KIND_SOLICIT);
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
			fail_count++;
		end
	endtask

	// watch all three channels; output words are compared before new ones queue up
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_mac         = rar_pkg::MAC_RESET;
			adv_prefix      = rar_pkg::PREFIX_RESET;
			rx_count        = 0;
			eth_ok          = 1'b0;
			dst_ok          = 1'b0;
			rs_ok           = 1'b0;
			tick_win        = 0;
			first_tick      = 1'b1;
			adv_due.delete();
			fail_count      = 0;
			words_due       = 0;
			solicit_bursts  = 0;
			periodic_bursts = 0;
			words_checked   = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (adv_due.size() == 0) begin
					$display("%0t: word with nothing pending, expected none, got %h",
						$time, out_data);
					fail_count++;
				end else begin
					adv_head = adv_due.pop_front();
					words_checked++;
					check_field("tx_word", adv_head.tx_word, out_data.tx_word);
					check_field("tx_last", 16'(adv_head.tx_last), 16'(out_data.tx_last));
					check_field("trigger_kind", 16'(adv_head.trigger_kind),
						16'(out_data.trigger_kind));
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rar_pkg::CFG_MAC:    own_mac    = cfg_data[47:0];
					rar_pkg::CFG_PREFIX: adv_prefix = cfg_data;
					default:             ;
				endcase
			end
			if (in_valid && in_ready)
				take_input(in_data);
			words_due = adv_due.size();
		end
	end

endmodule

// ===== tb/sv/ipv6_router_advert_responder_unit_tb.sv =====
`timescale 1ns / 1ps

module ipv6_router_advert_responder_unit_tb;

	// indexes with no register behind them
	localparam logic [rar_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
	localparam logic [rar_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

	localparam int POS_ETYPE = 12;
	localparam int POS_DST   = 38;
	localparam int POS_ICMP  = 54;

	// ticks until the periodic window wraps, and the ticks sent without idling
	localparam int WRAP_TICKS    = 1 << rar_pkg::PERIOD_LOG2_DEF;
	localparam int CALM_TICKS    = 12;
	localparam int SETTLE_CYCLES = 8;

	typedef enum {FR_SOLICIT, FR_BROKEN, FR_NOISE} frame_kind_t;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_ready;
	rar_pkg::in_t                  in_data   = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	rar_pkg::out_t                 out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [rar_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]                   cfg_data  = '0;

	bit calm          = 1'b0;
	int words_sent    = 0;
	int ticks_sent    = 0;
	int settings_used = 0;

	int fail_count;
	int words_due;
	int solicit_bursts;
	int periodic_bursts;
	int words_checked;

	ipv6_router_advert_responder_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ipv6_router_advert_responder_unit_chk u_adv_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.out_data        (out_data),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.fail_count      (fail_count),
		.words_due       (words_due),
		.solicit_bursts  (solicit_bursts),
		.periodic_bursts (periodic_bursts),
		.words_checked   (words_checked)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// run limit
	initial begin
		#10_000_000;
		$display("%0t: timeout, %0d advertisement words still pending", $time, words_due);
		$display("FAILED: results differ");
		$finish;
	end

	// receiver stalls in bursts, none once calm
	initial begin
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 7) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	// one input word, with an optional gap in front
	task automatic send_word(input logic c, input logic [7:0] b, input logic last);
		rar_pkg::in_t w;
		w.cmd       = c;
		w.rx_byte   = b;
		w.frame_end = last;
		if (!calm && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		words_sent++;
	endtask

	// byte and end mark are don't-care on a tick
	task automatic send_tick();
		send_word(rar_pkg::CMD_TICK, 8'($urandom), 1'($urandom));
		ticks_sent++;
	endtask

	// frame with a solicitation header, a broken one, or random bytes;
	// optionally one tick somewhere inside
	task automatic send_frame(input frame_kind_t kind, input int len, input bit ticks);
		int         pos;
		int         bad_pos;
		int         tick_pos;
		int         r;
		logic [7:0] b;
		bad_pos  = -1;
		tick_pos = ticks ? int'($urandom_range(0, len - 1)) : -1;
		if (kind == FR_BROKEN) begin
			r       = $urandom_range(0, 18);
			bad_pos = (r < 2) ? POS_ETYPE + r : POS_DST - 2 + r;
		end
		for (pos = 0; pos < len; pos++) begin
			if (pos == tick_pos)
				send_tick();
			b = 8'($urandom);
			if (kind != FR_NOISE) begin
				case (pos)
					POS_ETYPE:     b = 8'h86;
					POS_ETYPE + 1: b = 8'hdd;
					POS_DST:       b = 8'hff;
					POS_DST + 1:   b = 8'h02;
					POS_DST + 15:  b = 8'h02;
					POS_ICMP:      b = 8'h85;
					default: begin
						if (pos > POS_DST && pos < POS_ICMP)
							b = 8'h00;
					end
				endcase
			end
			if (pos == bad_pos)
				b = b ^ 8'($urandom_range(1, 255));
			send_word(rar_pkg::CMD_BYTE, b, pos == len - 1);
		end
	endtask

	// let all bursts drain and the pipeline settle
	task automatic wait_drain();
		in_valid <= 1'b0;
		do
			@(negedge clk);
		while (words_due != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rar_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// upper mac bits carry junk, the block keeps only 48
	task automatic apply_setting(input logic [47:0] mac, input logic [63:0] pfx,
			input bit spare);
		wait_drain();
		write_reg(rar_pkg::CFG_MAC, {16'($urandom), mac});
		write_reg(rar_pkg::CFG_PREFIX, pfx);
		if (spare) begin
			write_reg(CFG_SPARE_LO, {$urandom, $urandom});
			write_reg(CFG_SPARE_HI, {$urandom, $urandom});
		end
		settings_used++;
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: first tick fires, second not
		send_tick();
		send_tick();
		// shortest answered frame
		send_frame(FR_SOLICIT, 55, 1'b0);

		// random setting, spare indexes; a frame one byte short or with one bad
		// header byte, a tick inside it
		apply_setting(48'({$urandom, $urandom}), {$urandom, $urandom}, 1'b1);
		if ($urandom_range(0, 1) == 0)
			send_frame(FR_SOLICIT, 54, 1'b1);
		else
			send_frame(FR_BROKEN, 55, 1'b1);

		// all-ones mac and prefix; ticks run up to the window wrap, one-byte frame first
		apply_setting(48'hffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 1'b0);
		send_frame(FR_NOISE, 1, 1'b0);
		while (ticks_sent < WRAP_TICKS + 1) begin
			calm = (ticks_sent >= WRAP_TICKS - CALM_TICKS);
			send_tick();
		end
		send_frame(FR_NOISE, 3, 1'b0);
		wait_drain();

		$display("Covered %0d input words under %0d register settings, %0d words checked.",
			words_sent, settings_used + 1, words_checked);
		$display("Bursts seen: %0d solicitation answers, %0d periodic advertisements.",
			solicit_bursts, periodic_bursts);
		if (fail_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
